// ----- rtl/core/image_block_downscaler_top_defines.svh -----
// Assertion macros shared by the downscaler modules.
`ifndef IMAGE_BLOCK_DOWNSCALER_TOP_DEFINES_SVH
`define IMAGE_BLOCK_DOWNSCALER_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge outside of reset.
`define IBD_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Checks that a consequence holds in the same cycle as its antecedent.
`define IBD_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ibd_pkg.sv -----
// Package with the constants, types and tables of the image block downscaler.
package ibd_pkg;

   localparam int MAX_FACTOR = 8;
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W   = 8;
   localparam int FACT_W  = 4;
   localparam int SIZE_W  = 13;
   localparam int POS_W   = 12;
   localparam int ADDR_W  = $clog2(MAX_WIDTH);
   localparam int KC_W    = $clog2(MAX_FACTOR);
   localparam int SUM_W   = 16;
   localparam int RECIP_W = 23;
   localparam int RECIP_SHIFT = 22;
   localparam int PROD_W  = SUM_W + RECIP_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FACTOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_MODE   = 3'd3;

   localparam logic [FACT_W-1:0] RST_FACTOR = 4'd2;
   localparam logic [SIZE_W-1:0] RST_WIDTH  = 13'd640;
   localparam logic [SIZE_W-1:0] RST_HEIGHT = 13'd480;
   localparam logic              RST_COLOR  = 1'b1;

   localparam logic [FACT_W-1:0] WEIGHTED_FACTOR = 4'd3;

   // Controls that the sequencer hands to every color lane.
   typedef struct packed {
      logic               cap;
      logic               rd_en;
      logic               wr_en;
      logic               mul_en;
      logic               first;
      logic [1:0]         shift;
      logic [ADDR_W-1:0]  addr;
      logic [RECIP_W-1:0] recip;
   } lane_ctl_type;

   // Position and strobe for the result merge stage.
   typedef struct packed {
      logic             load;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             frame_done;
      logic             color;
   } out_info_type;

   // Reciprocal of the block divisor scaled by 2^RECIP_SHIFT and rounded up.
   // The weighted three-by-three block divides by 16, every other factor by f*f.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [FACT_W-1:0] f);
      logic [RECIP_W-1:0] r;
      case (f)
         4'd2:    r = 23'd1048576;
         4'd3:    r = 23'd262144;
         4'd4:    r = 23'd262144;
         4'd5:    r = 23'd167773;
         4'd6:    r = 23'd116509;
         4'd7:    r = 23'd85599;
         4'd8:    r = 23'd65536;
         default: r = 23'd4194304;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/ibd_pixel_if.sv -----
// Input pixel channel interface.
interface ibd_pixel_if;
   logic                      valid;
   logic                      ready;
   logic [ibd_pkg::PIX_W-1:0] pixel_red;
   logic [ibd_pkg::PIX_W-1:0] pixel_green;
   logic [ibd_pkg::PIX_W-1:0] pixel_blue;

   modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                   input ready);
   modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                   output ready);
endinterface

// ----- rtl/core/ibd_result_if.sv -----
// Output pixel channel interface.
interface ibd_result_if;
   logic                      valid;
   logic                      ready;
   logic [ibd_pkg::PIX_W-1:0] out_red;
   logic [ibd_pkg::PIX_W-1:0] out_green;
   logic [ibd_pkg::PIX_W-1:0] out_blue;
   logic [ibd_pkg::POS_W-1:0] out_column;
   logic [ibd_pkg::POS_W-1:0] out_row;
   logic                      frame_done;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output out_column, output out_row, output frame_done, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input out_column, input out_row, input frame_done, output ready);
endinterface

// ----- rtl/core/ibd_csr_if.sv -----
// Configuration write channel interface.
interface ibd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ibd_pkg::CSR_IDX_W-1:0]  index;
   logic [ibd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/image_block_downscaler_top.sv -----
// Top level of the image block downscaler: sequencer, three color lanes and merge stage.
// A pixel outside the cropped area only moves the position; one inside it passes the read
// and accumulate states for the read-modify-write of the per-column accumulator memory in
// each lane, and a block's bottom-right pixel then waits in the output state for the merge
// stage. No new pixel is taken before idle. Reset is synchronous and restores factor 2,
// 640 by 480, color mode and position zero; the accumulator memories are not cleared.
module image_block_downscaler_top (
   input  logic          clock,
   input  logic          reset,
   ibd_pixel_if.sink     req_if,
   ibd_result_if.source  rsp_if,
   ibd_csr_if.sink       csr_if
);

   // The sequencer tracks the raster position of each transferred pixel and
   // decides whether it falls inside the cropped image. A configuration write
   // to any listed register restarts the frame at the top-left pixel.
   ibd_pkg::lane_ctl_type     lane_ctl;
   ibd_pkg::out_info_type     out_info;
   logic                      color_en;
   logic                      out_free;
   logic [ibd_pkg::PIX_W-1:0] quot_red;
   logic [ibd_pkg::PIX_W-1:0] quot_green;
   logic [ibd_pkg::PIX_W-1:0] quot_blue;

   ibd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .csr_if   (csr_if),
      .out_free (out_free),
      .lane_ctl (lane_ctl),
      .color_en (color_en),
      .out_info (out_info)
   );

   // Three identical lanes run in lockstep, one per color channel. Each keeps
   // one accumulator per output column for the current block row, adds the
   // (possibly weighted) sample, and divides the finished block sum by a
   // multiply with a rounded-up reciprocal, exact for every 16-bit sum.
   // In gray mode the green and blue lanes do not update their memories.
   ibd_lane u_lane_red (
      .clock   (clock),
      .ctl     (lane_ctl),
      .wr_gate (1'b1),
      .pixel   (req_if.pixel_red),
      .quot    (quot_red)
   );

   ibd_lane u_lane_green (
      .clock   (clock),
      .ctl     (lane_ctl),
      .wr_gate (color_en),
      .pixel   (req_if.pixel_green),
      .quot    (quot_green)
   );

   ibd_lane u_lane_blue (
      .clock   (clock),
      .ctl     (lane_ctl),
      .wr_gate (color_en),
      .pixel   (req_if.pixel_blue),
      .quot    (quot_blue)
   );

   // The merge stage holds one finished result. New pixels are taken while
   // that result waits for its transfer; only a second finished block waits.
   ibd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .info       (out_info),
      .quot_red   (quot_red),
      .quot_green (quot_green),
      .quot_blue  (quot_blue),
      .out_free   (out_free),
      .rsp_if     (rsp_if)
   );

endmodule

// ----- rtl/core/ibd_lane.sv -----
// One color lane: per-column accumulator memory, weighted add and reciprocal divide.
module ibd_lane (
   input  logic                        clock,
   input  ibd_pkg::lane_ctl_type       ctl,
   input  logic                        wr_gate,
   input  logic [ibd_pkg::PIX_W-1:0]   pixel,
   output logic [ibd_pkg::PIX_W-1:0]   quot
);

   logic [ibd_pkg::SUM_W-1:0]  mem [ibd_pkg::MAX_WIDTH];
   logic [ibd_pkg::PIX_W-1:0]  pix_ff;
   logic [ibd_pkg::SUM_W-1:0]  rd_ff;
   logic [ibd_pkg::PROD_W-1:0] prod_ff;
   logic [ibd_pkg::SUM_W-1:0]  term;
   logic [ibd_pkg::SUM_W-1:0]  sum;

   // The weight of the three-by-three kernel is a power of two, so a shift.
   assign term = ibd_pkg::SUM_W'(pix_ff) << ctl.shift;
   assign sum  = ctl.first ? term : rd_ff + term;

   always_ff @(posedge clock) begin
      if (ctl.cap) begin
         pix_ff <= pixel;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem[ctl.addr];
      end
      if (ctl.mul_en) begin
         prod_ff <= ibd_pkg::PROD_W'(sum) * ibd_pkg::PROD_W'(ctl.recip);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en && wr_gate) begin
         mem[ctl.addr] <= sum;
      end
   end

   assign quot = prod_ff[ibd_pkg::RECIP_SHIFT +: ibd_pkg::PIX_W];

endmodule

// ----- rtl/core/ibd_ctrl.sv -----
// Sequencer: configuration registers, raster position tracking and lane control.
`include "image_block_downscaler_top_defines.svh"

module ibd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   ibd_pixel_if.sink             req_if,
   ibd_csr_if.sink               csr_if,
   input  logic                  out_free,
   output ibd_pkg::lane_ctl_type lane_ctl,
   output logic                  color_en,
   output ibd_pkg::out_info_type out_info
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_ACC  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [ibd_pkg::FACT_W-1:0] f_ff, f_in;
   logic [ibd_pkg::SIZE_W-1:0] w_ff, w_in;
   logic [ibd_pkg::SIZE_W-1:0] h_ff, h_in;
   logic                       color_ff, color_in;

   logic [ibd_pkg::POS_W-1:0]  col_ff, col_in;
   logic [ibd_pkg::KC_W-1:0]   kc_ff, kc_in;
   logic [ibd_pkg::POS_W-1:0]  oc_ff, oc_in;
   logic [ibd_pkg::POS_W-1:0]  cbase_ff, cbase_in;
   logic [ibd_pkg::POS_W-1:0]  row_ff, row_in;
   logic [ibd_pkg::KC_W-1:0]   kr_ff, kr_in;
   logic [ibd_pkg::POS_W-1:0]  orow_ff, orow_in;
   logic [ibd_pkg::POS_W-1:0]  rbase_ff, rbase_in;

   logic [ibd_pkg::ADDR_W-1:0] addr_ff;
   logic [ibd_pkg::POS_W-1:0]  crow_ff;
   logic                       first_ff, emit_ff, last_ff;
   logic [1:0]                 shift_ff;

   logic req_fire, csr_fire, csr_hit;
   logic col_wrap, row_wrap, kc_wrap, kr_wrap;
   logic col_crop, row_crop, col_end, row_end, in_crop;
   logic [1:0] shift_now;
   logic [ibd_pkg::CSR_DATA_W-1:0] wdata;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign wdata        = csr_if.data;

   // Configuration writes, clamped to the legal range as they are stored.
   always_comb begin
      f_in     = f_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      color_in = color_ff;
      csr_hit  = 1'b0;
      if (csr_fire) begin
         unique case (csr_if.index)
            ibd_pkg::REG_SCALE_FACTOR: begin
               csr_hit = 1'b1;
               if (wdata[ibd_pkg::FACT_W-1:0] == '0) begin
                  f_in = ibd_pkg::FACT_W'(1);
               end else if (wdata[ibd_pkg::FACT_W-1:0] > ibd_pkg::FACT_W'(ibd_pkg::MAX_FACTOR)) begin
                  f_in = ibd_pkg::FACT_W'(ibd_pkg::MAX_FACTOR);
               end else begin
                  f_in = wdata[ibd_pkg::FACT_W-1:0];
               end
            end
            ibd_pkg::REG_IMAGE_WIDTH: begin
               csr_hit = 1'b1;
               if (wdata == '0) begin
                  w_in = ibd_pkg::SIZE_W'(1);
               end else if (wdata > ibd_pkg::SIZE_W'(ibd_pkg::MAX_WIDTH)) begin
                  w_in = ibd_pkg::SIZE_W'(ibd_pkg::MAX_WIDTH);
               end else begin
                  w_in = wdata;
               end
            end
            ibd_pkg::REG_IMAGE_HEIGHT: begin
               csr_hit = 1'b1;
               if (wdata == '0) begin
                  h_in = ibd_pkg::SIZE_W'(1);
               end else if (wdata > ibd_pkg::SIZE_W'(ibd_pkg::MAX_HEIGHT)) begin
                  h_in = ibd_pkg::SIZE_W'(ibd_pkg::MAX_HEIGHT);
               end else begin
                  h_in = wdata;
               end
            end
            ibd_pkg::REG_COLOR_MODE: begin
               csr_hit  = 1'b1;
               color_in = wdata[0];
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // Position decode of the pixel now at the input.
   assign col_wrap = (ibd_pkg::SIZE_W'(col_ff) + ibd_pkg::SIZE_W'(1)) >= w_ff;
   assign row_wrap = (ibd_pkg::SIZE_W'(row_ff) + ibd_pkg::SIZE_W'(1)) >= h_ff;
   assign kc_wrap  = (ibd_pkg::FACT_W'(kc_ff) + ibd_pkg::FACT_W'(1)) == f_ff;
   assign kr_wrap  = (ibd_pkg::FACT_W'(kr_ff) + ibd_pkg::FACT_W'(1)) == f_ff;
   assign col_crop = (ibd_pkg::SIZE_W'(cbase_ff) + ibd_pkg::SIZE_W'(f_ff)) <= w_ff;
   assign row_crop = (ibd_pkg::SIZE_W'(rbase_ff) + ibd_pkg::SIZE_W'(f_ff)) <= h_ff;
   assign col_end  = (14'(cbase_ff) + 14'({f_ff, 1'b0})) > 14'(w_ff);
   assign row_end  = (14'(rbase_ff) + 14'({f_ff, 1'b0})) > 14'(h_ff);
   assign in_crop  = col_crop && row_crop;

   always_comb begin
      shift_now = 2'd0;
      if (f_ff == ibd_pkg::WEIGHTED_FACTOR) begin
         shift_now = 2'({1'b0, kr_ff == ibd_pkg::KC_W'(1)}) +
                     2'({1'b0, kc_ff == ibd_pkg::KC_W'(1)});
      end
   end

   // Raster counters; the block offset and block base follow the column and row.
   always_comb begin
      col_in   = col_ff;
      kc_in    = kc_ff;
      oc_in    = oc_ff;
      cbase_in = cbase_ff;
      row_in   = row_ff;
      kr_in    = kr_ff;
      orow_in  = orow_ff;
      rbase_in = rbase_ff;
      if (csr_hit) begin
         col_in   = '0;
         kc_in    = '0;
         oc_in    = '0;
         cbase_in = '0;
         row_in   = '0;
         kr_in    = '0;
         orow_in  = '0;
         rbase_in = '0;
      end else if (req_fire) begin
         if (col_wrap) begin
            col_in   = '0;
            kc_in    = '0;
            oc_in    = '0;
            cbase_in = '0;
            if (row_wrap) begin
               row_in   = '0;
               kr_in    = '0;
               orow_in  = '0;
               rbase_in = '0;
            end else begin
               row_in = row_ff + ibd_pkg::POS_W'(1);
               if (kr_wrap) begin
                  kr_in    = '0;
                  orow_in  = orow_ff + ibd_pkg::POS_W'(1);
                  rbase_in = rbase_ff + ibd_pkg::POS_W'(f_ff);
               end else begin
                  kr_in = kr_ff + ibd_pkg::KC_W'(1);
               end
            end
         end else begin
            col_in = col_ff + ibd_pkg::POS_W'(1);
            if (kc_wrap) begin
               kc_in    = '0;
               oc_in    = oc_ff + ibd_pkg::POS_W'(1);
               cbase_in = cbase_ff + ibd_pkg::POS_W'(f_ff);
            end else begin
               kc_in = kc_ff + ibd_pkg::KC_W'(1);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && in_crop) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            state_in = emit_ff ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         f_ff     <= ibd_pkg::RST_FACTOR;
         w_ff     <= ibd_pkg::RST_WIDTH;
         h_ff     <= ibd_pkg::RST_HEIGHT;
         color_ff <= ibd_pkg::RST_COLOR;
         col_ff   <= '0;
         kc_ff    <= '0;
         oc_ff    <= '0;
         cbase_ff <= '0;
         row_ff   <= '0;
         kr_ff    <= '0;
         orow_ff  <= '0;
         rbase_ff <= '0;
      end else begin
         state_ff <= state_in;
         f_ff     <= f_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         color_ff <= color_in;
         col_ff   <= col_in;
         kc_ff    <= kc_in;
         oc_ff    <= oc_in;
         cbase_ff <= cbase_in;
         row_ff   <= row_in;
         kr_ff    <= kr_in;
         orow_ff  <= orow_in;
         rbase_ff <= rbase_in;
      end
   end

   // Per-pixel command, held while the lanes work on it.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff  <= oc_ff[ibd_pkg::ADDR_W-1:0];
         crow_ff  <= orow_ff;
         first_ff <= (kc_ff == '0) && (kr_ff == '0);
         shift_ff <= shift_now;
         emit_ff  <= kc_wrap && kr_wrap;
         last_ff  <= col_end && row_end;
      end
   end

   always_comb begin
      lane_ctl.cap    = req_fire;
      lane_ctl.rd_en  = (state_ff == S_READ);
      lane_ctl.wr_en  = (state_ff == S_ACC);
      lane_ctl.mul_en = (state_ff == S_ACC) && emit_ff;
      lane_ctl.first  = first_ff;
      lane_ctl.shift  = shift_ff;
      lane_ctl.addr   = addr_ff;
      lane_ctl.recip  = ibd_pkg::recip_of(f_ff);
   end

   assign color_en = color_ff;

   always_comb begin
      out_info.load       = (state_ff == S_OUT) && out_free;
      out_info.column     = ibd_pkg::POS_W'(addr_ff);
      out_info.row        = crow_ff;
      out_info.frame_done = last_ff;
      out_info.color      = color_ff;
   end

   `IBD_ASSERT_ALWAYS(a_kc_in_block, ibd_pkg::FACT_W'(kc_ff) < f_ff, "column offset left the block")
   `IBD_ASSERT_ALWAYS(a_col_base, (cbase_ff + ibd_pkg::POS_W'(kc_ff)) == col_ff, "column base drift")
   `IBD_ASSERT_ALWAYS(a_row_base, (rbase_ff + ibd_pkg::POS_W'(kr_ff)) == row_ff, "row base drift")

endmodule

// ----- rtl/core/ibd_merge.sv -----
// Merge stage: combines the lane quotients with the block position into the result register.
`include "image_block_downscaler_top_defines.svh"

module ibd_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  ibd_pkg::out_info_type     info,
   input  logic [ibd_pkg::PIX_W-1:0] quot_red,
   input  logic [ibd_pkg::PIX_W-1:0] quot_green,
   input  logic [ibd_pkg::PIX_W-1:0] quot_blue,
   output logic                      out_free,
   ibd_result_if.source              rsp_if
);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ibd_pkg::PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic [ibd_pkg::POS_W-1:0] column_ff, row_ff;
   logic                      done_ff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (info.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Gray mode carries only the red lane; the other two read as zero.
   always_ff @(posedge clock) begin
      if (info.load) begin
         red_ff    <= quot_red;
         green_ff  <= info.color ? quot_green : '0;
         blue_ff   <= info.color ? quot_blue : '0;
         column_ff <= info.column;
         row_ff    <= info.row;
         done_ff   <= info.frame_done;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_red    = red_ff;
   assign rsp_if.out_green  = green_ff;
   assign rsp_if.out_blue   = blue_ff;
   assign rsp_if.out_column = column_ff;
   assign rsp_if.out_row    = row_ff;
   assign rsp_if.frame_done = done_ff;

   `IBD_ASSERT_IMPLIES(a_no_overwrite, info.load, !rsp_valid_ff || rsp_if.ready, "result overwritten")

endmodule

// ----- verif/ibd_downscale_checker.sv -----
// Checker that predicts each downscaled output pixel and compares it with the result channel.
module ibd_downscale_checker
   import ibd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   ibd_pixel_if  px,
   ibd_result_if rs,
   ibd_csr_if    cs,
   output int    fail_count,
   output int    pending,
   output int    pixel_count,
   output int    result_count,
   output int    frame_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WEIGHTED_DIVISOR = 16;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             frame_done;
   } block_avg_type;

   block_avg_type avg_queue[$];

   logic [FACT_W-1:0] factor_reg;
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   logic              color_reg;
   int unsigned       col_pos;
   int unsigned       row_pos;

   logic [SUM_W-1:0] red_acc   [MAX_WIDTH];
   logic [SUM_W-1:0] green_acc [MAX_WIDTH];
   logic [SUM_W-1:0] blue_acc  [MAX_WIDTH];

   function automatic int unsigned limit_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // A write to a listed register also restarts the frame; other indexes are no-ops.
   task automatic apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_SCALE_FACTOR: factor_reg = data[FACT_W-1:0];
         REG_IMAGE_WIDTH:  width_reg  = data;
         REG_IMAGE_HEIGHT: height_reg = data;
         REG_COLOR_MODE:   color_reg  = data[0];
         default:          return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic fold_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      int unsigned   f, w, h, cw, ch, col, row, kr, kc, oc, orow, wt, den, slot;
      logic          first;
      block_avg_type avg;
      f  = limit_size(factor_reg, MAX_FACTOR);
      w  = limit_size(width_reg, MAX_WIDTH);
      h  = limit_size(height_reg, MAX_HEIGHT);
      cw = w - w % f;
      ch = h - h % f;
      col = col_pos;
      row = row_pos;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      // Pixels in the cropped-away border are consumed silently.
      if (col >= cw || row >= ch) return;
      kr    = row % f;
      kc    = col % f;
      oc    = col / f;
      orow  = row / f;
      slot  = oc % MAX_WIDTH;
      first = (kr == 0 && kc == 0);
      wt    = 1;
      den   = f * f;
      if (f == WEIGHTED_FACTOR) begin
         wt  = ((kr == 1) ? 2 : 1) * ((kc == 1) ? 2 : 1);
         den = WEIGHTED_DIVISOR;
      end
      red_acc[slot] = SUM_W'(first ? r * wt : red_acc[slot] + r * wt);
      if (color_reg) begin
         green_acc[slot] = SUM_W'(first ? g * wt : green_acc[slot] + g * wt);
         blue_acc[slot]  = SUM_W'(first ? b * wt : blue_acc[slot] + b * wt);
      end
      if (kr != f - 1 || kc != f - 1) return;
      avg.red        = PIX_W'(red_acc[slot] / den);
      avg.green      = color_reg ? PIX_W'(green_acc[slot] / den) : '0;
      avg.blue       = color_reg ? PIX_W'(blue_acc[slot] / den) : '0;
      avg.column     = POS_W'(oc);
      avg.row        = POS_W'(orow);
      avg.frame_done = (col == cw - 1 && row == ch - 1);
      avg_queue.push_back(avg);
   endtask

   task automatic check_field(string name, int unsigned want, logic [POS_W-1:0] got);
      if (got !== POS_W'(want)) begin
         fail_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic check_avg();
      block_avg_type want;
      result_count++;
      if (rs.frame_done === 1'b1) frame_count++;
      if (avg_queue.size() == 0) begin
         fail_count++;
         $display("%0t: output pixel with none expected: rgb %0d %0d %0d col %0d row %0d done %0d",
                  $time, rs.out_red, rs.out_green, rs.out_blue, rs.out_column, rs.out_row,
                  rs.frame_done);
         return;
      end
      want = avg_queue.pop_front();
      check_field("out_red", want.red, rs.out_red);
      check_field("out_green", want.green, rs.out_green);
      check_field("out_blue", want.blue, rs.out_blue);
      check_field("out_column", want.column, rs.out_column);
      check_field("out_row", want.row, rs.out_row);
      check_field("frame_done", want.frame_done, rs.frame_done);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         factor_reg   = RST_FACTOR;
         width_reg    = RST_WIDTH;
         height_reg   = RST_HEIGHT;
         color_reg    = RST_COLOR;
         col_pos      = 0;
         row_pos      = 0;
         fail_count   = 0;
         pixel_count  = 0;
         result_count = 0;
         frame_count  = 0;
         avg_queue.delete();
      end else begin
         if (rs.valid && rs.ready) check_avg();
         if (cs.valid && cs.ready) apply_csr(cs.index, cs.data);
         if (px.valid && px.ready) begin
            pixel_count++;
            fold_pixel(px.pixel_red, px.pixel_green, px.pixel_blue);
         end
      end
      pending = avg_queue.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the image block downscaler: clock, reset, stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ibd_pkg::*;

   // The drain wait after the last expected result lets the block finish its last pixel
   // and leaves the block fully quiet.
   localparam int     DRAIN_CYCLES     = 16;
   localparam int     LONG_HOLD_CYCLES = 400;
   localparam int     RANDOM_PIXELS    = 1200;
   localparam int     QUIET_TAIL       = 300;
   localparam longint TIMEOUT_NS       = 10_000_000;

   // An index past the register list; writing it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd6;

   logic clock;
   logic reset;

   ibd_pixel_if  px_bus ();
   ibd_result_if avg_bus ();
   ibd_csr_if    csr_bus ();

   int fail_count;
   int pending;
   int pixel_count;
   int result_count;
   int frame_count;
   int setting_count;

   // Knobs shared between the sender and the receiver processes.
   bit gaps_on;
   bit stalls_on;
   bit hold_request;

   image_block_downscaler_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (px_bus),
      .rsp_if (avg_bus),
      .csr_if (csr_bus)
   );

   ibd_downscale_checker avg_check (
      .clock        (clock),
      .reset        (reset),
      .px           (px_bus),
      .rs           (avg_bus),
      .cs           (csr_bus),
      .fail_count   (fail_count),
      .pending      (pending),
      .pixel_count  (pixel_count),
      .result_count (result_count),
      .frame_count  (frame_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or loses a transfer.
   initial begin
      #(TIMEOUT_NS);
      $display("%0t: run timed out with %0d output pixels outstanding", $time, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver. It applies back-pressure in short random bursts while stalls are enabled, and
   // once holds off for a long stretch so that the block fills and stalls its input. Each
   // pass through the loop makes exactly one assignment to ready at one falling edge.
   initial begin
      avg_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            avg_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            avg_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clock);
         end else begin
            avg_bus.ready <= 1'b1;
         end
      end
   end

   // Pixel values lean toward the extremes now and then so that saturated sums show up.
   function automatic logic [PIX_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Offers one pixel and returns at the falling edge after its transfer. Valid is left high
   // so that back-to-back pixels stream without a bubble; an idle burst or settle() lowers it.
   task automatic put_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         px_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      px_bus.valid       <= 1'b1;
      px_bus.pixel_red   <= r;
      px_bus.pixel_green <= g;
      px_bus.pixel_blue  <= b;
      @(posedge clock);
      while (!px_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put_pixels(int unsigned count);
      repeat (count) put_pixel(pick_sample(), pick_sample(), pick_sample());
   endtask

   // Stops offering pixels, waits for every predicted output pixel and then lets the block
   // finish any pixel that produces no output before the next register write.
   task automatic settle();
      px_bus.valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes all four registers back to back. The unused upper data bits of the factor and
   // color registers carry random junk, which the block must ignore.
   task automatic configure(int unsigned fd, int unsigned wd, int unsigned hd, int unsigned c);
      write_reg(REG_SCALE_FACTOR, {(CSR_DATA_W - FACT_W)'($urandom), FACT_W'(fd)});
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(wd));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(hd));
      write_reg(REG_COLOR_MODE, {(CSR_DATA_W - 1)'($urandom), 1'(c)});
      csr_bus.valid <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int unsigned sent;
      int unsigned fd;
      int unsigned fe;
      int unsigned wd;
      int unsigned hd;
      int unsigned we;
      int unsigned he;
      int unsigned frame;
      bit          quiet;

      reset              = 1'b1;
      px_bus.valid       = 1'b0;
      px_bus.pixel_red   = '0;
      px_bus.pixel_green = '0;
      px_bus.pixel_blue  = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      gaps_on            = 1'b1;
      stalls_on          = 1'b1;
      hold_request       = 1'b0;
      setting_count      = 0;
      sent               = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The weighted three-by-three kernel with full-scale red, alternating
      // green and black blue, so the 1-2-1 weights and the divide by 16 are both visible.
      configure(3, 3, 3, 1);
      for (int i = 0; i < 9; i++) begin
         put_pixel('1, (i % 2 == 1) ? '1 : '0, '0);
      end
      settle();

      // A zero factor acts as one and zero sizes act as one, in gray mode: every pixel is a
      // complete one-pixel frame and green and blue must come out as zero.
      configure(0, 0, 0, 0);
      put_pixel('1, '1, '1);
      put_pixel(8'h5a, 8'ha5, 8'h3c);
      settle();

      // A factor above the maximum acts as eight, so this 3 by 2 image is smaller than one
      // block: nothing comes out, yet the position still wraps at the end of the frame.
      configure(15, 3, 2, 1);
      put_pixels(6);
      settle();

      // Factor two on a 3 by 2 image: one output pixel, the third column is dropped.
      configure(2, 3, 2, 1);
      put_pixels(6);
      settle();

      // A write to an index past the register list must not restart the frame, so the
      // second row still completes the block started before the write.
      configure(2, 2, 2, 1);
      put_pixels(2);
      settle();
      write_reg(REG_SPARE, '1);
      csr_bus.valid <= 1'b0;
      put_pixels(2);
      settle();

      // Oversized width: it acts as the maximum and factor zero acts as one, so every pixel
      // is an output pixel. The frame is cut short; the next register write restarts it.
      configure(0, 13'h1fff, 0, 1);
      put_pixels(300);
      settle();

      // Oversized height in gray mode, one pixel wide. The frame is cut short on purpose;
      // the next register write has to restart it.
      configure(1, 1, 13'h1fff, 0);
      put_pixels(200);
      settle();

      // Long receiver hold-off while the sender keeps pushing one output per pixel, then a
      // pause until everything is out, then the second half of the same frame.
      configure(1, 16, 16, 1);
      hold_request = 1'b1;
      put_pixels(128);
      px_bus.valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
      put_pixels(128);
      settle();

      // Random part: one register setting per phase with one or two whole frames of random
      // content, sometimes followed by a truncated frame that the next setting cuts off.
      // Idling is switched per phase and turned off for the tail of the run.
      while (sent < RANDOM_PIXELS) begin
         quiet     = (sent >= RANDOM_PIXELS - QUIET_TAIL);
         gaps_on   = !quiet && ($urandom_range(0, 3) != 0);
         stalls_on = !quiet && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       fd = 0;
            1:       fd = $urandom_range(MAX_FACTOR + 1, 15);
            default: fd = $urandom_range(1, MAX_FACTOR);
         endcase
         fe = (fd == 0) ? 1 : (fd > MAX_FACTOR) ? MAX_FACTOR : fd;
         if ($urandom_range(0, 9) == 0) begin
            wd = $urandom_range(0, fe);
         end else begin
            wd = fe * $urandom_range(1, 3) + $urandom_range(0, fe - 1);
         end
         if ($urandom_range(0, 9) == 0) begin
            hd = $urandom_range(0, fe);
         end else begin
            hd = fe * $urandom_range(1, 2) + $urandom_range(0, fe - 1);
         end
         we    = (wd == 0) ? 1 : wd;
         he    = (hd == 0) ? 1 : hd;
         frame = we * he;
         configure(fd, wd, hd, $urandom_range(0, 1));
         repeat ($urandom_range(1, 2)) begin
            put_pixels(frame);
            sent += frame;
         end
         if ($urandom_range(0, 3) == 0) begin
            frame = $urandom_range(1, frame);
            put_pixels(frame);
            sent += frame;
         end
         settle();
      end

      $display("Run covered %0d pixel transfers, %0d output pixels and %0d frame ends",
               pixel_count, result_count, frame_count);
      $display("over %0d register settings in color and gray mode with cropping and stalls.",
               setting_count);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
